@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for the concurrent checks in the positional list rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PLST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plst assertion failed");

// next-cycle implication
`define PLST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plst assertion failed");

`endif

@@ rtl/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg
// request codes, status codes, states and cell control for the list engine
// ----------------------------------------------------------------------------
package plst_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } plst_op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_POS   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } plst_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } plst_state_type;

   typedef struct packed {
      logic capture;
      logic do_insert;
      logic do_remove;
   } plst_cell_ctl_type;

endpackage

@@ rtl/plst_cell.sv @@
// ----------------------------------------------------------------------------
// plst_cell
// one list slot: holds an entry, compares it, shifts toward either neighbor
// ----------------------------------------------------------------------------
module plst_cell #(
   parameter int ITEM_BITS = 32,
   parameter int IDX_W     = 6,
   parameter int CNT_W     = 7,
   parameter int IDX       = 0
) (
   input  logic                         clock,
   input  plst_pkg::plst_cell_ctl_type  ctl,
   input  logic [IDX_W-1:0]             slot,
   input  logic [CNT_W-1:0]             count,
   input  logic [ITEM_BITS-1:0]         cmp_item,
   input  logic [ITEM_BITS-1:0]         new_item,
   input  logic [ITEM_BITS-1:0]         left_value,
   input  logic [ITEM_BITS-1:0]         right_value,
   input  logic                         found_in,
   input  logic [ITEM_BITS-1:0]         rd_in,
   output logic [ITEM_BITS-1:0]         value,
   output logic                         found_out,
   output logic [ITEM_BITS-1:0]         rd_out
);
   import plst_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

   logic [ITEM_BITS-1:0] value_ff;
   logic [ITEM_BITS-1:0] value_in;
   logic                 match_ff;
   logic                 in_list;
   logic                 at_slot;

   assign in_list   = (MY_CNT < count);
   assign at_slot   = (slot == MY_IDX);
   // first match at or before this slot
   assign found_out = found_in | (match_ff & in_list);
   assign rd_out    = rd_in | (at_slot ? value_ff : '0);
   assign value     = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.do_insert) begin
         if (at_slot) begin
            value_in = new_item;
         end else if (MY_IDX > slot) begin
            value_in = left_value;
         end
      end else if (ctl.do_remove && found_out) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (ctl.capture) begin
         match_ff <= (value_ff == cmp_item);
      end
   end

endmodule

@@ rtl/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of up to CAPACITY entries held in a row of shifting cells
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one request word (insert, remove first match, read, clear),
//   accepted when req_valid is high and req_stall low. rsp_ returns exactly
//   one word per request: status, value read, entry count and empty flag.
//   in the accept cycle of a request every cell compares its entry with
//   req_item_value; in the execute state that follows, the first-match chain
//   along the cells resolves and, once the output register is free, an insert
//   or remove makes the cells shift or load at once. req_stall is high
//   throughout the execute state, so no new request is taken until the
//   current one completes, and rsp_valid is set by a register at that point.
//   the response sits in an output register; while rsp_stall holds it, a new
//   request is still accepted and waits in the execute cycle until the
//   register frees up.
//   reset empties the list and drops any pending response; entry contents
//   are not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine #(
   parameter int CAPACITY  = 64,
   parameter int ITEM_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_item_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [6:0]  rsp_item_count,
   output logic        rsp_is_empty
);
   import plst_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

   plst_state_type        state_ff, state_in;
   plst_op_type           op_ff;
   logic [6:0]            pos_ff;
   logic [ITEM_BITS-1:0]  item_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic                  rsp_valid_ff;
   plst_status_type       rsp_status_ff;
   logic [31:0]           rsp_read_value_ff;
   logic [6:0]            rsp_item_count_ff;
   logic                  rsp_is_empty_ff;

   logic                  accept;
   logic                  out_free;
   logic                  fire;
   plst_cell_ctl_type     ctl;
   plst_status_type       status;
   logic [31:0]           read_value;
   logic [IDX_W-1:0]      slot;
   logic [6:0]            pos_m1;
   logic [CMP_W-1:0]      pos_ext, cnt_ext;
   logic                  ins_bad, ins_full, rd_bad, empty, found;
   logic [ITEM_BITS-1:0]  cmp_item;

   logic [ITEM_BITS-1:0]  value_w [CAPACITY];
   logic [ITEM_BITS-1:0]  left_w  [CAPACITY];
   logic [ITEM_BITS-1:0]  right_w [CAPACITY];
   logic                  found_w [CAPACITY+1];
   logic [ITEM_BITS-1:0]  rd_w    [CAPACITY+1];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = (state_ff == S_EXEC) & out_free;
   assign cmp_item  = ITEM_BITS'(req_item_value);

   assign pos_m1  = pos_ff - 7'd1;
   assign slot    = IDX_W'(pos_m1);
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign empty   = (count_ff == '0);
   assign ins_bad = (pos_ff == 7'd0) || (pos_ext > cnt_ext + CMP_W'(1));
   assign ins_full = (cnt_ext >= CAP_CMP);
   assign rd_bad  = (pos_ff == 7'd0) || (pos_ext > cnt_ext);
   assign found   = found_w[CAPACITY];

   // cell row
   assign found_w[0] = 1'b0;
   assign rd_w[0]    = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_w[g] = item_ff;
      end else begin : g_mid
         assign left_w[g] = value_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign right_w[g] = value_w[g];
      end else begin : g_body
         assign right_w[g] = value_w[g+1];
      end

      plst_cell #(
         .ITEM_BITS (ITEM_BITS),
         .IDX_W     (IDX_W),
         .CNT_W     (CNT_W),
         .IDX       (g)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .slot        (slot),
         .count       (count_ff),
         .cmp_item    (cmp_item),
         .new_item    (item_ff),
         .left_value  (left_w[g]),
         .right_value (right_w[g]),
         .found_in    (found_w[g]),
         .rd_in       (rd_w[g]),
         .value       (value_w[g]),
         .found_out   (found_w[g+1]),
         .rd_out      (rd_w[g+1])
      );
   end

   // request decode and next state
   always_comb begin
      state_in      = state_ff;
      ctl.capture   = accept;
      ctl.do_insert = 1'b0;
      ctl.do_remove = 1'b0;
      count_in      = count_ff;
      status        = ST_OK;
      read_value    = '0;

      case (op_ff)
         OP_INSERT: begin
            if (ins_bad) begin
               status = ST_BAD_POS;
            end else if (ins_full) begin
               status = ST_FULL;
            end else begin
               ctl.do_insert = fire;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOT_FOUND;
            end else begin
               ctl.do_remove = fire;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (rd_bad) begin
               status = ST_BAD_POS;
            end else begin
               read_value = 32'(rd_w[CAPACITY]);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status = ST_OK;
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= plst_op_type'(req_type);
         pos_ff  <= req_position;
         item_ff <= cmp_item;
      end
      if (fire) begin
         rsp_status_ff     <= status;
         rsp_read_value_ff <= read_value;
         rsp_item_count_ff <= 7'(count_in);
         rsp_is_empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_item_count = rsp_item_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;

   `PLST_ASSERT_IMP(a_count_in_range, clock, reset, 1'b1, count_ff <= CAP_CNT)
   `PLST_ASSERT_IMP(a_remove_nonempty, clock, reset, ctl.do_remove, count_ff != '0)
   `PLST_ASSERT_NXT(a_insert_grows, clock, reset, ctl.do_insert, count_ff == $past(count_ff) + CNT_W'(1))
   `PLST_ASSERT_NXT(a_remove_shrinks, clock, reset, ctl.do_remove, count_ff == $past(count_ff) - CNT_W'(1))

endmodule
